FILE: src/assert_macros.svh
// Assertion macros shared by the numeric literal validator modules.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define NLV_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define NLV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/nlv_pkg.sv
// ----------------------------------------------------------------------------
// nlv_pkg
// Shared types and constants of the numeric literal validator: character
// classes, the classified item passed from front to back, result codes.
// ----------------------------------------------------------------------------
package nlv_pkg;

    localparam int CHAR_W      = 21;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CHAR_W-1:0] CH_MINUS   = CHAR_W'(32'h2D);
    localparam logic [CHAR_W-1:0] CH_PLUS    = CHAR_W'(32'h2B);
    localparam logic [CHAR_W-1:0] CH_ZERO    = CHAR_W'(32'h30);
    localparam logic [CHAR_W-1:0] CH_NINE    = CHAR_W'(32'h39);
    localparam logic [CHAR_W-1:0] CH_DOT     = CHAR_W'(32'h2E);
    localparam logic [CHAR_W-1:0] CH_EXP_LO  = CHAR_W'(32'h65);
    localparam logic [CHAR_W-1:0] CH_EXP_UP  = CHAR_W'(32'h45);

    localparam logic [CFG_IDX_W-1:0] CFG_INT_EXP_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DEC_EXP_LIMIT = CFG_IDX_W'(1);

    localparam logic [CFG_DATA_W-1:0] INT_EXP_LIMIT_RST = CFG_DATA_W'(4);
    localparam logic [CFG_DATA_W-1:0] DEC_EXP_LIMIT_RST = CFG_DATA_W'(0);

    typedef enum logic [2:0] {
        CC_ZERO  = 3'd0,
        CC_DIGIT = 3'd1,
        CC_MINUS = 3'd2,
        CC_PLUS  = 3'd3,
        CC_DOT   = 3'd4,
        CC_EXP   = 3'd5,
        CC_OTHER = 3'd6
    } t_char_class;

    typedef struct packed {
        t_char_class cls;
        logic        kind;
        logic        last;
    } t_token;

    typedef struct packed {
        logic                  wr_en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_MISSING     = 3'd1,
        ST_NON_DIGIT   = 3'd2,
        ST_LEAD_ZERO   = 3'd3,
        ST_NEG_EXP     = 3'd4,
        ST_EXP_LONG    = 3'd5,
        ST_MISSING_DOT = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        PART_NONE = 2'd0,
        PART_INT  = 2'd1,
        PART_FRAC = 2'd2,
        PART_EXP  = 2'd3
    } t_part;

    typedef struct packed {
        t_status status;
        t_part   part;
    } t_verdict;

endpackage

FILE: src/numeric_literal_validator.sv
// ----------------------------------------------------------------------------
// numeric_literal_validator: checks integer and decimal literal text.
// Throughput one character per cycle while full is low; the verdict reaches the
// result ports through the item queue and the verdict register.
// An unpopped verdict holds back the next last character; the 4-entry queue
// then fills and raises full. Synchronous active-low reset clears queue and
// state and restores the limits.
// ----------------------------------------------------------------------------
module numeric_literal_validator #(
    parameter int QUEUE_DEPTH = nlv_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [nlv_pkg::CHAR_W-1:0]     i_char_code,
    input  logic                           i_literal_kind,
    input  logic                           i_last_char,
    output logic                           empty,
    input  logic                           pop,
    output logic [2:0]                     o_status,
    output logic [1:0]                     o_error_part,
    input  logic                           i_cfg_wr_en,
    input  logic [nlv_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [nlv_pkg::CFG_DATA_W-1:0] i_cfg_wr_data
);
    import nlv_pkg::*;

    logic    q_wr;
    logic    q_rd;
    logic    q_empty;
    t_token  front_tok;
    t_token  back_tok;
    t_cfg_wr cfg;

    assign cfg.wr_en = i_cfg_wr_en;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_wr_data;

    nlv_front u_front (
        .i_push         (push),
        .i_full         (full),
        .i_char_code    (i_char_code),
        .i_literal_kind (i_literal_kind),
        .i_last_char    (i_last_char),
        .o_wr           (q_wr),
        .o_tok          (front_tok)
    );

    nlv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_tok   (front_tok),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_tok   (back_tok)
    );

    nlv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_tok_valid  (!q_empty),
        .i_tok        (back_tok),
        .o_tok_rd     (q_rd),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_status     (o_status),
        .o_error_part (o_error_part)
    );

endmodule

FILE: src/nlv_front.sv
// ----------------------------------------------------------------------------
// nlv_front
// Input side: takes one character per cycle while the queue is not full and reduces
// it to a character class with the kind and last flags, ready for the item queue.
// ----------------------------------------------------------------------------
module nlv_front (
    input  logic                       i_push,
    input  logic                       i_full,
    input  logic [nlv_pkg::CHAR_W-1:0] i_char_code,
    input  logic                       i_literal_kind,
    input  logic                       i_last_char,
    output logic                       o_wr,
    output nlv_pkg::t_token            o_tok
);
    import nlv_pkg::*;

    function automatic t_char_class classify(input logic [CHAR_W-1:0] c);
        t_char_class cls;
        if (c == CH_ZERO) begin
            cls = CC_ZERO;
        end else if (c > CH_ZERO && c <= CH_NINE) begin
            cls = CC_DIGIT;
        end else if (c == CH_MINUS) begin
            cls = CC_MINUS;
        end else if (c == CH_PLUS) begin
            cls = CC_PLUS;
        end else if (c == CH_DOT) begin
            cls = CC_DOT;
        end else if (c == CH_EXP_LO || c == CH_EXP_UP) begin
            cls = CC_EXP;
        end else begin
            cls = CC_OTHER;
        end
        return cls;
    endfunction

    assign o_wr       = i_push && !i_full;
    assign o_tok.cls  = classify(i_char_code);
    assign o_tok.kind = i_literal_kind;
    assign o_tok.last = i_last_char;

endmodule

FILE: src/nlv_queue.sv
// ----------------------------------------------------------------------------
// nlv_queue
// Short item queue between front and back, so that each side can stall on
// its own.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nlv_queue #(
    parameter int DEPTH = nlv_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  nlv_pkg::t_token i_tok,
    output logic            o_full,
    input  logic            i_rd,
    output logic            o_empty,
    output nlv_pkg::t_token o_tok
);
    import nlv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_token             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic               do_wr;
    logic               do_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_tok   = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_rd) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `NLV_ASSERT_IMPL(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH), "queue count above depth")
    `NLV_ASSERT_NEXT(a_count_up, do_wr && !do_rd, r_count == $past(r_count) + 1'b1, "queue count missed a write")
    `NLV_ASSERT_NEXT(a_count_down, do_rd && !do_wr, r_count == $past(r_count) - 1'b1, "queue count missed a read")
    `NLV_ASSERT_IMPL(a_ptr_match, r_wr_ptr != r_rd_ptr, r_count != '0 && !o_full, "queue pointers disagree with count")

endmodule

FILE: src/nlv_back.sv
// ----------------------------------------------------------------------------
// nlv_back
// Back end: walks the literal state machine one item per cycle, a last item only once
// the result slot is free; holds the exponent digit limits; gives the verdict on the last character.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nlv_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  nlv_pkg::t_cfg_wr i_cfg,
    input  logic             i_tok_valid,
    input  nlv_pkg::t_token  i_tok,
    output logic             o_tok_rd,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [2:0]       o_status,
    output logic [1:0]       o_error_part
);
    import nlv_pkg::*;

    typedef enum logic [4:0] {
        PH_START = 5'b00001,
        PH_INT   = 5'b00010,
        PH_FRAC  = 5'b00100,
        PH_ESIGN = 5'b01000,
        PH_EXP   = 5'b10000
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic       kind;
        logic [1:0] int_cnt;
        logic       int_zero;
        logic       int_bad;
        logic       frac_ne;
        logic       frac_bad;
        logic       dot;
        logic       exp_seen;
        logic       exp_neg;
        logic [4:0] exp_cnt;
        logic       exp_zero;
        logic       exp_bad;
    } t_lit_state;

    localparam t_lit_state LIT_CLEAR = '{
        phase: PH_START, kind: 1'b0, int_cnt: 2'd0, int_zero: 1'b0, int_bad: 1'b0,
        frac_ne: 1'b0, frac_bad: 1'b0, dot: 1'b0, exp_seen: 1'b0, exp_neg: 1'b0,
        exp_cnt: 5'd0, exp_zero: 1'b0, exp_bad: 1'b0
    };

    localparam logic [1:0] INT_CNT_MAX = 2'd2;
    localparam logic [4:0] EXP_CNT_MAX = 5'd16;

    function automatic t_verdict judge(input t_lit_state s,
                                       input logic [CFG_DATA_W-1:0] int_lim,
                                       input logic [CFG_DATA_W-1:0] dec_lim);
        t_verdict                v;
        logic [CFG_DATA_W-1:0]   lim;
        lim = s.kind ? dec_lim : int_lim;
        priority if (s.exp_seen && s.exp_neg) begin
            v = '{ST_NEG_EXP, PART_EXP};
        end else if (s.exp_seen && s.exp_cnt == '0) begin
            v = '{ST_MISSING, PART_EXP};
        end else if (s.exp_seen && s.exp_bad) begin
            v = '{ST_NON_DIGIT, PART_EXP};
        end else if (s.exp_seen && s.exp_cnt > 5'd1 && s.exp_zero) begin
            v = '{ST_LEAD_ZERO, PART_EXP};
        end else if (s.exp_seen && lim != '0 && s.exp_cnt > 5'(lim)) begin
            v = '{ST_EXP_LONG, PART_EXP};
        end else if (s.kind && !s.dot) begin
            v = '{ST_MISSING_DOT, PART_NONE};
        end else if (s.int_cnt == '0) begin
            v = '{ST_MISSING, PART_INT};
        end else if (s.int_bad) begin
            v = '{ST_NON_DIGIT, PART_INT};
        end else if (s.int_cnt > 2'd1 && s.int_zero) begin
            v = '{ST_LEAD_ZERO, PART_INT};
        end else if (s.kind && !s.frac_ne) begin
            v = '{ST_MISSING, PART_FRAC};
        end else if (s.kind && s.frac_bad) begin
            v = '{ST_NON_DIGIT, PART_FRAC};
        end else begin
            v = '{ST_OK, PART_NONE};
        end
        return v;
    endfunction

    t_lit_state            r_st;
    t_lit_state            n_st;
    logic [CFG_DATA_W-1:0] r_int_lim;
    logic [CFG_DATA_W-1:0] r_dec_lim;
    logic                  r_out_valid;
    t_verdict              r_verdict;
    logic                  kind_eff;
    logic                  is_dig;
    logic                  do_int;
    logic                  do_exp;
    logic                  out_free;
    logic                  take;

    assign out_free     = !r_out_valid || i_pop;
    assign take         = i_tok_valid && (!i_tok.last || out_free);
    assign o_tok_rd     = take;
    assign o_empty      = !r_out_valid;
    assign o_status     = r_verdict.status;
    assign o_error_part = r_verdict.part;

    always_comb begin
        n_st     = r_st;
        do_int   = 1'b0;
        do_exp   = 1'b0;
        kind_eff = (r_st.phase == PH_START) ? i_tok.kind : r_st.kind;
        is_dig   = (i_tok.cls == CC_ZERO) || (i_tok.cls == CC_DIGIT);
        unique case (r_st.phase)
            PH_START: begin
                n_st.kind  = i_tok.kind;
                n_st.phase = PH_INT;
                do_int     = (i_tok.cls != CC_MINUS);
            end
            PH_INT: begin
                do_int = 1'b1;
            end
            PH_FRAC: begin
                if (i_tok.cls == CC_EXP) begin
                    n_st.exp_seen = 1'b1;
                    n_st.phase    = PH_ESIGN;
                end else begin
                    n_st.frac_ne = 1'b1;
                    if (!is_dig) begin
                        n_st.frac_bad = 1'b1;
                    end
                end
            end
            PH_ESIGN: begin
                n_st.phase = PH_EXP;
                if (i_tok.cls == CC_PLUS || i_tok.cls == CC_MINUS) begin
                    if (i_tok.cls == CC_MINUS && !r_st.kind) begin
                        n_st.exp_neg = 1'b1;
                    end
                end else begin
                    do_exp = 1'b1;
                end
            end
            PH_EXP: begin
                do_exp = 1'b1;
            end
            default: begin
                n_st.phase = PH_START;
            end
        endcase

        if (do_int) begin
            if (i_tok.cls == CC_EXP) begin
                n_st.exp_seen = 1'b1;
                n_st.phase    = PH_ESIGN;
            end else if (kind_eff && i_tok.cls == CC_DOT) begin
                n_st.dot   = 1'b1;
                n_st.phase = PH_FRAC;
            end else begin
                if (r_st.int_cnt == '0) begin
                    n_st.int_zero = (i_tok.cls == CC_ZERO);
                end
                if (r_st.int_cnt < INT_CNT_MAX) begin
                    n_st.int_cnt = r_st.int_cnt + 1'b1;
                end
                if (!is_dig) begin
                    n_st.int_bad = 1'b1;
                end
            end
        end

        if (do_exp) begin
            if (r_st.exp_cnt == '0) begin
                n_st.exp_zero = (i_tok.cls == CC_ZERO);
            end
            if (r_st.exp_cnt < EXP_CNT_MAX) begin
                n_st.exp_cnt = r_st.exp_cnt + 1'b1;
            end
            if (!is_dig) begin
                n_st.exp_bad = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_lim <= INT_EXP_LIMIT_RST;
            r_dec_lim <= DEC_EXP_LIMIT_RST;
        end else if (i_cfg.wr_en) begin
            unique case (i_cfg.index)
                CFG_INT_EXP_LIMIT: r_int_lim <= i_cfg.data;
                CFG_DEC_EXP_LIMIT: r_dec_lim <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= LIT_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_st <= i_tok.last ? LIT_CLEAR : n_st;
            end
            if (take && i_tok.last) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_tok.last) begin
            r_verdict <= judge(n_st, r_int_lim, r_dec_lim);
        end
    end

    `NLV_ASSERT_IMPL(a_result_from_last, $rose(r_out_valid), $past(take && i_tok.last), "result without a last item")
    `NLV_ASSERT_NEXT(a_clear_after_last, take && i_tok.last, r_st.phase == PH_START, "state not cleared after last item")
    `NLV_ASSERT_IMPL(a_ok_no_part, r_out_valid && r_verdict.status == ST_OK, r_verdict.part == PART_NONE, "ok verdict with a failing part")
    `NLV_ASSERT_IMPL(a_count_sat, 1'b1, r_st.int_cnt <= INT_CNT_MAX && r_st.exp_cnt <= EXP_CNT_MAX, "digit count past saturation")

endmodule

FILE: verif/numeric_literal_validator_tb.sv
// ----------------------------------------------------------------------------
// numeric_literal_validator_tb
// Feeds integer and decimal literal text one character at a time, predicts
// each verdict in a local literal scanner and compares it against the
// block's results. Mixes directed literals, a result-side hold-off, and
// randomised literals under several exponent limit settings.
// ----------------------------------------------------------------------------
module numeric_literal_validator_tb;
    import nlv_pkg::*;

    localparam int ITEMS_PER_SETTING = 110;
    localparam int SETTING_COUNT     = 8;
    localparam int SETTLE_CYCLES     = 8;
    localparam int HOLD_OFF_CYCLES   = 120;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = CFG_IDX_W'(3);

    typedef enum logic [2:0] {
        LIT_START,
        LIT_INT,
        LIT_FRAC,
        LIT_EXP_SIGN,
        LIT_EXP_DIGITS
    } t_lit_phase;

    typedef struct packed {
        t_lit_phase  phase;
        logic        kind;
        logic [1:0]  int_len;
        logic        int_lead_zero;
        logic        int_bad;
        logic        frac_any;
        logic        frac_bad;
        logic        dot;
        logic        exp_on;
        logic        exp_neg;
        logic [4:0]  exp_len;
        logic        exp_lead_zero;
        logic        exp_bad;
    } t_lit_state;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic [CHAR_W-1:0]     char_code = '0;
    logic                  literal_kind = 1'b0;
    logic                  last_char = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [2:0]            status;
    logic [1:0]            error_part;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    t_lit_state            lit = '0;
    logic [CFG_DATA_W-1:0] int_exp_limit = INT_EXP_LIMIT_RST;
    logic [CFG_DATA_W-1:0] dec_exp_limit = DEC_EXP_LIMIT_RST;
    t_verdict              expected_verdicts[$];

    bit          send_idle_on = 1'b1;
    bit          recv_idle_on = 1'b1;
    int unsigned hold_cycles = 0;
    int unsigned chars_sent = 0;
    int unsigned verdicts_checked = 0;
    int unsigned settings_used = 0;
    int unsigned mismatches = 0;

    numeric_literal_validator dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .push           (push),
        .full           (full),
        .i_char_code    (char_code),
        .i_literal_kind (literal_kind),
        .i_last_char    (last_char),
        .empty          (empty),
        .pop            (pop),
        .o_status       (status),
        .o_error_part   (error_part),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wr_data  (cfg_wr_data)
    );

    always #5 clk = ~clk;

    function automatic bit is_dec_digit(logic [CHAR_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_exp_mark(logic [CHAR_W-1:0] c);
        return c == CH_EXP_LO || c == CH_EXP_UP;
    endfunction

    function automatic void exponent_char(logic [CHAR_W-1:0] c);
        if (lit.exp_len == 0) lit.exp_lead_zero = (c == CH_ZERO);
        if (lit.exp_len < 16) lit.exp_len++;
        if (!is_dec_digit(c)) lit.exp_bad = 1'b1;
    endfunction

    function automatic void mantissa_char(logic [CHAR_W-1:0] c);
        if (is_exp_mark(c)) begin
            lit.exp_on = 1'b1;
            lit.phase  = LIT_EXP_SIGN;
        end else if (lit.kind && c == CH_DOT) begin
            lit.dot   = 1'b1;
            lit.phase = LIT_FRAC;
        end else begin
            if (lit.int_len == 0) lit.int_lead_zero = (c == CH_ZERO);
            if (lit.int_len < 2) lit.int_len++;
            if (!is_dec_digit(c)) lit.int_bad = 1'b1;
        end
    endfunction

    function automatic t_verdict literal_verdict();
        logic [CFG_DATA_W-1:0] limit;
        t_verdict v;
        limit    = lit.kind ? dec_exp_limit : int_exp_limit;
        v.status = ST_OK;
        v.part   = PART_NONE;
        if (lit.exp_on) begin
            v.part = PART_EXP;
            if (lit.exp_neg) v.status = ST_NEG_EXP;
            else if (lit.exp_len == 0) v.status = ST_MISSING;
            else if (lit.exp_bad) v.status = ST_NON_DIGIT;
            else if (lit.exp_len > 1 && lit.exp_lead_zero) v.status = ST_LEAD_ZERO;
            else if (limit != 0 && lit.exp_len > 5'(limit)) v.status = ST_EXP_LONG;
            if (v.status != ST_OK) return v;
            v.part = PART_NONE;
        end
        if (lit.kind && !lit.dot) begin
            v.status = ST_MISSING_DOT;
            return v;
        end
        v.part = PART_INT;
        if (lit.int_len == 0) v.status = ST_MISSING;
        else if (lit.int_bad) v.status = ST_NON_DIGIT;
        else if (lit.int_len > 1 && lit.int_lead_zero) v.status = ST_LEAD_ZERO;
        else if (lit.kind) begin
            v.part = PART_FRAC;
            if (!lit.frac_any) v.status = ST_MISSING;
            else if (lit.frac_bad) v.status = ST_NON_DIGIT;
        end
        if (v.status == ST_OK) v.part = PART_NONE;
        return v;
    endfunction

    function automatic bit lex_char(logic [CHAR_W-1:0] c, logic kind, logic last,
                                    output t_verdict v);
        v = '0;
        case (lit.phase)
            LIT_START: begin
                lit.kind  = kind;
                lit.phase = LIT_INT;
                if (c != CH_MINUS) mantissa_char(c);
            end
            LIT_INT: mantissa_char(c);
            LIT_FRAC: begin
                if (is_exp_mark(c)) begin
                    lit.exp_on = 1'b1;
                    lit.phase  = LIT_EXP_SIGN;
                end else begin
                    lit.frac_any = 1'b1;
                    if (!is_dec_digit(c)) lit.frac_bad = 1'b1;
                end
            end
            LIT_EXP_SIGN: begin
                lit.phase = LIT_EXP_DIGITS;
                if (c == CH_PLUS || c == CH_MINUS) begin
                    if (c == CH_MINUS && !lit.kind) lit.exp_neg = 1'b1;
                end else begin
                    exponent_char(c);
                end
            end
            default: exponent_char(c);
        endcase
        if (!last) return 1'b0;
        v   = literal_verdict();
        lit = '0;
        return 1'b1;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char();
        if ($urandom_range(0, 3) == 0) return CH_ZERO;
        return CH_ZERO + CHAR_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [CHAR_W-1:0] noise_char();
        case ($urandom_range(0, 3))
            0: return CHAR_W'($urandom);
            1: begin
                case ($urandom_range(0, 7))
                    0: return CH_MINUS;
                    1: return CH_PLUS;
                    2: return CH_DOT;
                    3: return CH_EXP_LO;
                    4: return CH_EXP_UP;
                    5: return CH_ZERO - 1'b1;
                    6: return CH_NINE + 1'b1;
                    default: return '0;
                endcase
            end
            2: return digit_char();
            default: return CHAR_W'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic kind, input logic last);
        int unsigned gap;
        t_verdict v;
        gap = send_idle_on ? pick_gap() : 0;
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        char_code    <= c;
        literal_kind <= kind;
        last_char    <= last;
        do @(posedge clk); while (full);
        chars_sent++;
        if (lex_char(c, kind, last, v)) expected_verdicts.push_back(v);
    endtask

    task automatic send_text(input string s, input logic kind);
        for (int i = 0; i < s.len(); i++) send_char(CHAR_W'(s[i]), kind, i == s.len() - 1);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_limits(input logic [CFG_DATA_W-1:0] int_lim,
                                input logic [CFG_DATA_W-1:0] dec_lim);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_INT_EXP_LIMIT;
        cfg_wr_data <= int_lim;
        @(posedge clk);
        cfg_index   <= CFG_DEC_EXP_LIMIT;
        cfg_wr_data <= dec_lim;
        @(posedge clk);
        cfg_index   <= $urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B;
        cfg_wr_data <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        int_exp_limit = int_lim;
        dec_exp_limit = dec_lim;
        settings_used++;
    endtask

    task automatic send_random_literal();
        logic [CHAR_W-1:0] text[$];
        logic kind;
        int n;
        kind = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) text.push_back(noise_char());
        end else begin
            if ($urandom_range(0, 3) == 0) text.push_back(CH_MINUS);
            n = $urandom_range(0, 3);
            repeat (n) text.push_back(digit_char());
            if (kind ? $urandom_range(0, 9) != 0 : $urandom_range(0, 19) == 0) begin
                text.push_back(CH_DOT);
                n = $urandom_range(0, 3);
                repeat (n) text.push_back(digit_char());
            end
            if ($urandom_range(0, 1) == 1) begin
                text.push_back($urandom_range(0, 1) ? CH_EXP_LO : CH_EXP_UP);
                case ($urandom_range(0, 2))
                    0: text.push_back(CH_PLUS);
                    1: text.push_back(CH_MINUS);
                    default: ;
                endcase
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 17) : $urandom_range(0, 5);
                repeat (n) text.push_back(digit_char());
            end
            if (text.size() != 0 && $urandom_range(0, 4) == 0)
                text[$urandom_range(0, text.size() - 1)] = noise_char();
        end
        if (text.size() == 0) text.push_back(digit_char());
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], (i == 0) ? kind : 1'($urandom_range(0, 1)),
                      i == text.size() - 1);
    endtask

    task automatic test_reset_limits();
        send_text("1e12345", 1'b0);
        send_text("1.0e12345", 1'b1);
        drain_results();
    endtask

    task automatic test_directed_verdicts();
        send_text("5", 1'b0);
        send_text("-", 1'b0);
        send_char('1, 1'b1, 1'b1);
        send_char('0, 1'b0, 1'b1);
        send_text("00", 1'b0);
        send_text("1e-", 1'b0);
        send_text("1.", 1'b1);
        send_text("1", 1'b1);
        drain_results();
    endtask

    task automatic test_result_backpressure();
        send_idle_on = 1'b0;
        hold_cycles  = HOLD_OFF_CYCLES;
        repeat (24) send_char($urandom_range(0, 1) ? digit_char() : noise_char(),
                              1'($urandom_range(0, 1)), 1'b1);
        drain_results();
        send_idle_on = 1'b1;
    endtask

    task automatic test_limit_settings();
        logic [CFG_DATA_W-1:0] il;
        logic [CFG_DATA_W-1:0] dl;
        int unsigned phase_start;
        for (int k = 0; k < SETTING_COUNT; k++) begin
            case (k)
                0: begin il = '0; dl = '0; end
                1: begin il = '1; dl = '1; end
                2: begin il = 4'd1; dl = 4'd1; end
                3: begin il = '1; dl = '0; end
                4: begin il = '0; dl = '1; end
                5: begin il = INT_EXP_LIMIT_RST; dl = DEC_EXP_LIMIT_RST; end
                default: begin il = CFG_DATA_W'($urandom); dl = CFG_DATA_W'($urandom); end
            endcase
            apply_limits(il, dl);
            send_idle_on = (k % 3 != 2);
            recv_idle_on = (k % 4 != 3);
            phase_start  = chars_sent;
            while (chars_sent - phase_start < ITEMS_PER_SETTING) send_random_literal();
            drain_results();
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    initial begin : pop_control
        int unsigned stall;
        forever begin
            @(posedge clk);
            stall = 0;
            if (hold_cycles != 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end else if (recv_idle_on) begin
                stall = pick_gap();
            end
            if (stall != 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
        end
    end

    always @(posedge clk) begin : verdict_check
        t_verdict want;
        if (rst_n && pop && !empty) begin
            verdicts_checked++;
            if (expected_verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d part %0d",
                                          status, error_part));
            end else begin
                want = expected_verdicts.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, want.status));
                if (error_part !== want.part)
                    report_mismatch($sformatf("error part %0d, expected %0d",
                                              error_part, want.part));
            end
        end
    end

    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_limits();
        test_directed_verdicts();
        test_result_backpressure();
        test_limit_settings();
        $display("sent %0d characters over %0d limit settings plus reset values",
                 chars_sent, settings_used);
        $display("compared %0d verdicts, including a %0d-cycle result hold-off",
                 verdicts_checked, HOLD_OFF_CYCLES);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
